// ===== rtl/core/edfvd_pkg.sv =====
package edfvd_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TaskBitsDefault   = 4;

  localparam int unsigned DemandW   = 16;
  localparam int unsigned KeyW      = 24;
  localparam int unsigned RealDlW   = 20;
  localparam int unsigned KeyFracW  = 4;
  localparam int unsigned OutTaskW  = 4;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic load_item;    // capture the incoming item
    logic scan_start;   // reset the scan index
    logic scan_step;    // examine one entry for the insert position
    logic shift_step;   // move one entry up to open the insert slot
    logic write_new;    // write the new job at the insert position
    logic tick_head;    // run the head job for one tick
    logic remove_step;  // move one entry down to close the head slot
    logic purge_step;   // examine one entry during the purge
    logic sort_start;   // begin the re-sort
    logic sort_step;    // one compare-exchange step of the re-sort
  } edfvd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic full;
    logic level_low_drop;
    logic empty;
    logic scan_hit;
    logic scan_end;
    logic shift_end;
    logic head_done;
    logic head_switch;
    logic remove_end;
    logic purge_end;
    logic sort_end;
  } edfvd_sts_t;

endpackage

// ===== rtl/core/edfvd_if.sv =====
interface edfvd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  task_id;
  logic        job_level;
  logic [15:0] exec_demand;
  logic [15:0] wcet_low;
  logic [23:0] virt_deadline;
  logic [19:0] real_deadline;

  modport source (output valid, op, task_id, job_level, exec_demand, wcet_low,
                  virt_deadline, real_deadline, input ready);
  modport sink (input valid, op, task_id, job_level, exec_demand, wcet_low,
                virt_deadline, real_deadline, output ready);
endinterface

interface edfvd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] running_task;
  logic       idle;
  logic       mode_switched;
  logic       job_done;
  logic       release_accepted;
  logic       current_level;

  modport source (output valid, running_task, idle, mode_switched, job_done,
                  release_accepted, current_level, input ready);
  modport sink (input valid, running_task, idle, mode_switched, job_done,
                release_accepted, current_level, output ready);
endinterface

// ===== rtl/core/edfvd_datapath.sv =====
module edfvd_datapath #(
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned TaskBits   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  edfvd_pkg::edfvd_cmd_t cmd_i,
  output edfvd_pkg::edfvd_sts_t sts_o,
  input  logic                 in_op_i,
  input  logic [3:0]           in_task_i,
  input  logic                 in_level_i,
  input  logic [15:0]          in_demand_i,
  input  logic [15:0]          in_wcet_i,
  input  logic [23:0]          in_vdl_i,
  input  logic [19:0]          in_rdl_i,
  output logic [3:0]           res_task_o,
  output logic                 res_level_o
);
  import edfvd_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [TaskBits-1:0] task_num;
    logic                level;
    logic [DemandW-1:0]  remaining;
    logic [DemandW-1:0]  executed;
    logic [DemandW-1:0]  budget;
    logic [KeyW-1:0]     key;
    logic [RealDlW-1:0]  real_dl;
  } entry_t;

  // Queue storage: one row per entry, read at a few indexes per cycle.
  entry_t mem_q [QueueDepth];

  logic [CntW-1:0] count_q;
  logic            level_q;
  logic [CntW-1:0] idx_q;   // scan/move index
  logic [CntW-1:0] wr_q;    // purge write index, sort outer index
  logic [CntW-1:0] pos_q;   // insert position
  entry_t          new_q;   // new job or sort carry
  logic            op_q;
  logic            head_done_q;
  logic            head_sw_q;
  logic [3:0]      res_task_q;

  entry_t rd_e, rd_prev;
  logic [KeyW-1:0] new_key;
  logic [DemandW-1:0] h_exec, h_rem;

  // Combinational reads at the current index and the one below it.
  always_comb begin
    rd_e    = mem_q[idx_q[IdxW-1:0]];
    rd_prev = mem_q[IdxW'(idx_q - CntW'(1))];
  end

  always_comb begin
    if (level_q) new_key = {in_rdl_i, KeyFracW'(0)};
    else         new_key = in_vdl_i;
  end

  // Head update for a tick.
  always_comb begin
    h_exec = (mem_q[0].executed != '1) ? mem_q[0].executed + 1'b1 : mem_q[0].executed;
    h_rem  = (mem_q[0].remaining != '0) ? mem_q[0].remaining - 1'b1 : '0;
  end

  always_comb begin
    sts_o = '0;
    sts_o.is_release     = op_q;
    sts_o.full           = (count_q >= CntW'(QueueDepth));
    sts_o.level_low_drop = (new_q.level < level_q);
    sts_o.empty          = (count_q == '0);
    sts_o.scan_end       = (idx_q >= count_q);
    sts_o.scan_hit       = (idx_q < count_q) && (rd_e.key > new_q.key);
    sts_o.shift_end      = (idx_q <= pos_q);
    sts_o.head_done      = head_done_q;
    sts_o.head_switch    = head_sw_q;
    sts_o.remove_end     = (idx_q + CntW'(1) >= count_q);
    sts_o.purge_end      = (idx_q >= count_q);
    // The re-sort ends when the outer index passes the last entry.
    sts_o.sort_end       = (wr_q >= count_q);
  end

  logic ins_move;
  assign ins_move = (idx_q != '0) && (rd_prev.key > new_q.key);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      new_q.task_num  <= in_task_i[TaskBits-1:0];
      new_q.level     <= in_level_i;
      new_q.remaining <= in_demand_i;
      new_q.executed  <= '0;
      new_q.budget    <= in_wcet_i;
      new_q.key       <= new_key;
      new_q.real_dl   <= in_rdl_i;
      op_q            <= in_op_i;
    end
    if (cmd_i.shift_step && !sts_o.shift_end) begin
      mem_q[idx_q[IdxW-1:0]] <= rd_prev;
    end
    if (cmd_i.write_new) mem_q[pos_q[IdxW-1:0]] <= new_q;
    if (cmd_i.tick_head) begin
      mem_q[0].executed  <= h_exec;
      mem_q[0].remaining <= h_rem;
      head_done_q <= (h_rem == '0) && !(!level_q && h_exec > mem_q[0].budget
                     && !mem_q[0].level);
      head_sw_q   <= !level_q && (h_exec > mem_q[0].budget);
      res_task_q  <= OutTaskW'(mem_q[0].task_num);
    end
    if (cmd_i.remove_step && !sts_o.remove_end) begin
      mem_q[idx_q[IdxW-1:0]] <= mem_q[IdxW'(idx_q + CntW'(1))];
    end
    if (cmd_i.purge_step && !sts_o.purge_end && rd_e.level) begin
      mem_q[wr_q[IdxW-1:0]] <= '{task_num: rd_e.task_num, level: rd_e.level,
        remaining: rd_e.remaining, executed: rd_e.executed, budget: rd_e.budget,
        key: {rd_e.real_dl, KeyFracW'(0)}, real_dl: rd_e.real_dl};
    end
    if (cmd_i.sort_step && !sts_o.sort_end) begin
      // Insertion sort: carry held in new_q, hole at idx_q.
      if (ins_move) mem_q[idx_q[IdxW-1:0]] <= rd_prev;
      else begin
        mem_q[idx_q[IdxW-1:0]] <= new_q;
        new_q <= mem_q[IdxW'(wr_q + CntW'(1))];
      end
    end
    if (cmd_i.sort_start) new_q <= mem_q[IdxW'(wr_q)];
  end

  // Control registers of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
      idx_q   <= '0;
      wr_q    <= '0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        idx_q <= '0;
        wr_q  <= '0;
      end
      if (cmd_i.scan_step) begin
        if (sts_o.scan_hit || sts_o.scan_end) begin
          pos_q <= idx_q;
          idx_q <= count_q;
        end else idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.shift_step && !sts_o.shift_end) idx_q <= idx_q - CntW'(1);
      if (cmd_i.write_new) count_q <= count_q + CntW'(1);
      if (cmd_i.tick_head) idx_q <= '0;
      if (cmd_i.remove_step) begin
        if (sts_o.remove_end) begin
          count_q <= count_q - CntW'(1);
          idx_q   <= '0;
        end else idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.purge_step) begin
        if (sts_o.purge_end) begin
          count_q <= wr_q;
          level_q <= 1'b1;
          wr_q    <= CntW'(1);
          idx_q   <= CntW'(1);
        end else begin
          if (rd_e.level) wr_q <= wr_q + CntW'(1);
          idx_q <= idx_q + CntW'(1);
        end
      end
      if (cmd_i.sort_start) idx_q <= wr_q;
      if (cmd_i.sort_step && !sts_o.sort_end && !ins_move) begin
        wr_q  <= wr_q + CntW'(1);
        idx_q <= wr_q + CntW'(1);
      end else if (cmd_i.sort_step && !sts_o.sort_end) begin
        idx_q <= idx_q - CntW'(1);
      end
    end
  end

  // The controller holds the result flags; task and level come from here.
  assign res_task_o  = res_task_q;
  assign res_level_o = level_q;

endmodule

// ===== rtl/core/edfvd_ctrl.sv =====
module edfvd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output edfvd_pkg::edfvd_cmd_t cmd_o,
  input  edfvd_pkg::edfvd_sts_t sts_i,
  output logic                  idle_o,
  output logic                  switch_o,
  output logic                  done_o,
  output logic                  accept_o,
  output logic                  task_zero_o
);
  import edfvd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_SHIFT, S_WRITE, S_TICK, S_EVAL,
    S_REMOVE, S_PURGE, S_SORT_START, S_SORT, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q, idle_q, sw_q, done_q, acc_q, tz_q;

  // A new item is taken only once the previous result has transferred.
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign idle_o      = idle_q;
  assign switch_o    = sw_q;
  assign done_o      = done_q;
  assign accept_o    = acc_q;
  assign task_zero_o = tz_q;

  // Command decode per state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:       cmd_o.load_item   = in_valid_i && in_ready_o;
      S_DECIDE:     cmd_o.scan_start  = 1'b1;
      S_SCAN:       cmd_o.scan_step   = 1'b1;
      S_SHIFT:      cmd_o.shift_step  = 1'b1;
      S_WRITE:      cmd_o.write_new   = 1'b1;
      S_TICK:       cmd_o.tick_head   = 1'b1;
      S_REMOVE:     cmd_o.remove_step = 1'b1;
      S_PURGE:      cmd_o.purge_step  = 1'b1;
      S_SORT_START: cmd_o.sort_start  = 1'b1;
      S_SORT:       cmd_o.sort_step   = 1'b1;
      default:      cmd_o = '0;
    endcase
  end

  // Sequencer and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      idle_q <= 1'b0; sw_q <= 1'b0; done_q <= 1'b0; acc_q <= 1'b0; tz_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) state_q <= S_DECIDE;
        S_DECIDE: begin
          idle_q <= 1'b0; sw_q <= 1'b0; done_q <= 1'b0; acc_q <= 1'b0; tz_q <= 1'b1;
          if (sts_i.is_release) begin
            if (sts_i.full || sts_i.level_low_drop) state_q <= S_OUT;
            else state_q <= S_SCAN;
          end else if (sts_i.empty) begin
            idle_q  <= 1'b1;
            state_q <= S_OUT;
          end else state_q <= S_TICK;
        end
        S_SCAN: if (sts_i.scan_hit || sts_i.scan_end) state_q <= S_SHIFT;
        S_SHIFT: if (sts_i.shift_end) state_q <= S_WRITE;
        S_WRITE: begin
          acc_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_TICK: begin
          tz_q <= 1'b0;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          done_q <= sts_i.head_done;
          sw_q   <= sts_i.head_switch;
          if (sts_i.head_done) state_q <= S_REMOVE;
          else if (sts_i.head_switch) state_q <= S_PURGE;
          else state_q <= S_OUT;
        end
        S_REMOVE: if (sts_i.remove_end) state_q <= sw_q ? S_PURGE : S_OUT;
        S_PURGE: if (sts_i.purge_end) state_q <= S_SORT_START;
        S_SORT_START: state_q <= S_SORT;
        S_SORT: if (sts_i.sort_end) state_q <= S_OUT;
        S_OUT: if (!out_valid_q) begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(acc_q && (sw_q || done_q || idle_q)))
    else $error("release result with tick flags");

endmodule

// ===== rtl/core/edf_vd_ready_queue_scheduler.sv =====
// EDF-VD ready queue with two criticality levels.
// in_if carries one item per transfer: a tick (op 0) or a job release
// (op 1). out_if returns exactly one result per item, in order.
// Releases are inserted in key order behind equal keys; a tick runs the
// head job, may finish it, and may raise the level to high, after which
// low jobs are purged and survivors re-sorted by actual deadline.
// A dropped release or an idle tick goes straight to the result; an
// accepted release scans to the insert point, then shifts the tail up,
// one entry per cycle; a tick runs the head job, then removes a finished
// job, and on the single tick that switches mode also purges the low
// jobs and insertion re-sorts the survivors.
// One item is in work at a time; the next is taken no earlier than the
// cycle after the result transfers.
// Reset clears the queue count and the level to low; entry storage is
// not cleared. When the receiver stalls, the result holds and no new
// item is taken until it transfers.
module edf_vd_ready_queue_scheduler #(
  parameter int unsigned QueueDepth = edfvd_pkg::QueueDepthDefault,
  parameter int unsigned TaskBits   = edfvd_pkg::TaskBitsDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  edfvd_in_if.sink  in_if,
  edfvd_out_if.source out_if
);
  import edfvd_pkg::*;

  edfvd_cmd_t cmd;
  edfvd_sts_t sts;
  logic [3:0] dp_task;
  logic dp_level;
  logic c_idle, c_sw, c_done, c_acc, c_tz;

  edfvd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts),
    .idle_o(c_idle), .switch_o(c_sw), .done_o(c_done), .accept_o(c_acc),
    .task_zero_o(c_tz)
  );

  edfvd_datapath #(.QueueDepth(QueueDepth), .TaskBits(TaskBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_op_i(in_if.op), .in_task_i(in_if.task_id), .in_level_i(in_if.job_level),
    .in_demand_i(in_if.exec_demand), .in_wcet_i(in_if.wcet_low),
    .in_vdl_i(in_if.virt_deadline), .in_rdl_i(in_if.real_deadline),
    .res_task_o(dp_task), .res_level_o(dp_level)
  );

  // Result fields: flags from the controller, task and level from the datapath.
  assign out_if.running_task     = c_tz ? 4'd0 : dp_task;
  assign out_if.idle             = c_idle;
  assign out_if.mode_switched    = c_sw;
  assign out_if.job_done         = c_done;
  assign out_if.release_accepted = c_acc;
  assign out_if.current_level    = dp_level;

endmodule

// ===== tb/edf_vd_ready_queue_scheduler_tb.sv =====
module edf_vd_ready_queue_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edfvd_pkg::*;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    op_e         op;
    logic [3:0]  task_id;
    logic        job_level;
    logic [15:0] exec_demand;
    logic [15:0] wcet_low;
    logic [23:0] virt_deadline;
    logic [19:0] real_deadline;
  } job_item_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       idle;
    logic       mode_switched;
    logic       job_done;
    logic       release_accepted;
    logic       current_level;
  } sched_res_t;

  typedef struct packed {
    logic [3:0]  task_id;
    logic        level;
    logic [15:0] remaining;
    logic [15:0] executed;
    logic [15:0] budget;
    logic [23:0] key;
    logic [19:0] real_dl;
  } job_slot_t;

  int unsigned err_cnt = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // Shadow ready queue that predicts each result and holds it until the
  // output transfer arrives.
  class sched_scoreboard;
    job_slot_t  slots[$];
    logic       sys_level;
    sched_res_t pending[$];

    function new();
      sys_level = 1'b0;
    endfunction

    function int unsigned queued();
      return slots.size();
    endfunction

    // Predict the result of one accepted item.
    function void note_item(job_item_t it);
      sched_res_t r;
      job_slot_t  s, h, kept[$];
      int         pos;
      logic       done, sw;
      r = '0;
      if (it.op == OP_RELEASE) begin
        if (slots.size() < Depth && it.job_level >= sys_level) begin
          s.task_id   = it.task_id;
          s.level     = it.job_level;
          s.remaining = it.exec_demand;
          s.executed  = '0;
          s.budget    = it.wcet_low;
          s.key       = sys_level ? {it.real_deadline, 4'b0} : it.virt_deadline;
          s.real_dl   = it.real_deadline;
          pos = slots.size();
          for (int i = 0; i < slots.size(); i++) begin
            if (slots[i].key > s.key) begin
              pos = i;
              break;
            end
          end
          slots.insert(pos, s);
          r.release_accepted = 1'b1;
        end
      end else if (slots.size() == 0) begin
        r.idle = 1'b1;
      end else begin
        h = slots[0];
        r.running_task = h.task_id;
        if (h.executed != 16'hffff) h.executed++;
        if (h.remaining != 0) h.remaining--;
        done = (h.remaining == 0);
        sw = !sys_level && (h.executed > h.budget);
        if (sw && !h.level) done = 1'b0;
        slots[0] = h;
        if (done) slots.delete(0);
        if (sw) begin
          // Purge low jobs, re-key by actual deadline, stable re-sort.
          sys_level = 1'b1;
          foreach (slots[i]) begin
            if (slots[i].level) begin
              s = slots[i];
              s.key = {s.real_dl, 4'b0};
              pos = kept.size();
              for (int j = 0; j < kept.size(); j++) begin
                if (kept[j].key > s.key) begin
                  pos = j;
                  break;
                end
              end
              kept.insert(pos, s);
            end
          end
          slots = kept;
        end
        r.mode_switched = sw;
        r.job_done = done;
      end
      r.current_level = sys_level;
      pending.push_back(r);
    endfunction

    // Compare one output transfer with the oldest prediction.
    task check_result(sched_res_t got);
      sched_res_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp = pending.pop_front();
      if (got.running_task != exp.running_task)
        report($sformatf("running_task %0d, expected %0d",
                         got.running_task, exp.running_task));
      if (got.idle != exp.idle)
        report($sformatf("idle %0b, expected %0b", got.idle, exp.idle));
      if (got.mode_switched != exp.mode_switched)
        report($sformatf("mode_switched %0b, expected %0b",
                         got.mode_switched, exp.mode_switched));
      if (got.job_done != exp.job_done)
        report($sformatf("job_done %0b, expected %0b", got.job_done, exp.job_done));
      if (got.release_accepted != exp.release_accepted)
        report($sformatf("release_accepted %0b, expected %0b",
                         got.release_accepted, exp.release_accepted));
      if (got.current_level != exp.current_level)
        report($sformatf("current_level %0b, expected %0b",
                         got.current_level, exp.current_level));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  edfvd_in_if  in_if ();
  edfvd_out_if out_if ();

  edf_vd_ready_queue_scheduler i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #4 clk_i = ~clk_i;

  sched_scoreboard sched_sb = new();

  // Receiver: random stalls, results checked at the rising edge.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sched_sb.check_result({out_if.running_task, out_if.idle, out_if.mode_switched,
                             out_if.job_done, out_if.release_accepted,
                             out_if.current_level});
    end
  end

  // Drive one item until it transfers, with a random lead-in gap. Valid is
  // dropped at the falling edge after the transfer and raised no earlier than
  // the next one.
  task automatic send_item(input job_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_if.valid         <= 1'b1;
    in_if.op            <= it.op;
    in_if.task_id       <= it.task_id;
    in_if.job_level     <= it.job_level;
    in_if.exec_demand   <= it.exec_demand;
    in_if.wcet_low      <= it.wcet_low;
    in_if.virt_deadline <= it.virt_deadline;
    in_if.real_deadline <= it.real_deadline;
    do @(posedge clk_i); while (!in_if.ready);
    sched_sb.note_item(it);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  function automatic job_item_t make_release(logic [3:0] id, logic lvl,
                                             logic [15:0] dem, logic [15:0] wc,
                                             logic [23:0] vd, logic [19:0] rd);
    job_item_t it;
    it.op = OP_RELEASE;
    it.task_id = id;
    it.job_level = lvl;
    it.exec_demand = dem;
    it.wcet_low = wc;
    it.virt_deadline = vd;
    it.real_deadline = rd;
    return it;
  endfunction

  // Tick with random contents in the unused fields.
  function automatic job_item_t make_tick();
    job_item_t it;
    it.op = OP_TICK;
    it.task_id = 4'($urandom);
    it.job_level = 1'($urandom);
    it.exec_demand = 16'($urandom);
    it.wcet_low = 16'($urandom);
    it.virt_deadline = 24'($urandom);
    it.real_deadline = 20'($urandom);
    return it;
  endfunction

  // Random item; demands mostly small so jobs finish and overruns happen.
  function automatic job_item_t rand_item(int unsigned tick_pct);
    job_item_t   it;
    logic [15:0] dem, wc;
    if ($urandom_range(99) < tick_pct) return make_tick();
    dem = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
    wc  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8));
    it = make_release(4'($urandom), 1'($urandom), dem, wc, 24'($urandom),
                      20'($urandom));
    if ($urandom_range(3) == 0) it.virt_deadline = 24'($urandom_range(7));
    if ($urandom_range(3) == 0) it.real_deadline = 20'($urandom_range(3));
    return it;
  endfunction

  // Directed opening: empty tick, extremes, full queue, mode switch.
  task automatic run_directed();
    send_item(make_tick());
    send_item(make_release(4'hf, 1'b1, 16'hffff, 16'hffff, 24'hffffff, 20'hfffff));
    send_item(make_release(4'h0, 1'b0, 16'h0000, 16'h0000, 24'h000000, 20'h00000));
    send_item(make_release(4'h5, 1'b1, 16'h0001, 16'h0005, 24'h000000, 20'h00003));
    for (int i = 0; i < 14; i++)
      send_item(make_release(4'(i), 1'(i), 16'(i + 1), 16'h0003, 24'h000010, 20'(i)));
    // Queue is full now; this release must be dropped.
    send_item(make_release(4'ha, 1'b1, 16'h0002, 16'h0002, 24'h0, 20'h1));
    for (int i = 0; i < 4; i++) send_item(make_tick());
  endtask

  // Random phase; near a full queue mostly ticks are sent so it drains.
  task automatic run_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (sched_sb.queued() >= Depth - 1 && $urandom_range(3) != 0)
        send_item(make_tick());
      else
        send_item(rand_item(45));
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_TICK;
    in_if.task_id = '0;
    in_if.job_level = 1'b0;
    in_if.exec_demand = '0;
    in_if.wcet_low = '0;
    in_if.virt_deadline = '0;
    in_if.real_deadline = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    send_idle_pct = 25;
    recv_stall_pct = 73;
    run_random(500);
    send_idle_pct = 73;
    recv_stall_pct = 25;
    run_random(500);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(500);
    while (sched_sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== edf_vd_ready_queue_scheduler.f =====
rtl/core/edfvd_pkg.sv
rtl/core/edfvd_if.sv
rtl/core/edfvd_datapath.sv
rtl/core/edfvd_ctrl.sv
rtl/core/edf_vd_ready_queue_scheduler.sv
tb/edf_vd_ready_queue_scheduler_tb.sv
